// ----- rtl/core/bsst_pkg.sv -----
package bsst_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int LIM_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int COUNT_W     = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SHORT = 2'd1;
    localparam logic [OP_W-1:0] OP_LONG  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_FEW  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VAL_W-1:0]   span;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_SH_START,
        S_SH_PRIME,
        S_SH_WALK,
        S_LG_START,
        S_LG_PRIME,
        S_LG_CALC,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/core/bsst_ram.sv -----
module bsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bounded_set_span_tracker.sv -----
// Holds up to min(capacity, 64) signed values, kept in ascending order in a RAM with
// one read and one write port, and answers add, shortest-span and longest-span items one
// at a time. Every RAM read returns its data registered, in the next cycle. An add moves
// each stored value larger than the new one up a slot, one read and one write at a time,
// and then writes the new value; a shortest-span query walks all neighbors through one
// subtractor, and a longest-span query subtracts the first value from the last. An add
// into an empty set, a rejected add, a query on fewer than two values and an unknown
// item go straight to the output stage. A stalled output delays the item that waits
// to be placed behind it.
// The block takes no new item until the current one has been placed in the output
// register, but it does take one while an earlier result still waits there.
module bounded_set_span_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         capacity_we,
    input  logic [bsst_pkg::CAP_W-1:0]   capacity_wdata,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  bsst_pkg::in_item_t           item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output bsst_pkg::out_item_t          result
);

    import bsst_pkg::*;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [VAL_W-1:0]     prev_reg, prev_next;
    logic [VAL_W-1:0]     best_reg, best_next;
    logic [ST_W-1:0]      res_status_reg, res_status_next;
    logic [VAL_W-1:0]     res_span_reg, res_span_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [VAL_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [VAL_W-1:0]     ram_rdata;

    logic [VAL_W:0]       sub_a, sub_b, sub_diff;
    logic [VAL_W-1:0]     best_min;
    logic [CNT_W-1:0]     pos_m1, count_m1;
    logic [LIM_W-1:0]     cap_ext, count_ext, limit;
    logic                 cnt_full, accept;

    bsst_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    assign cap_ext   = LIM_W'(cap_reg);
    assign count_ext = LIM_W'(count_reg);
    assign limit     = (cap_ext < LIM_W'(MAX_ENTRIES)) ? cap_ext : LIM_W'(MAX_ENTRIES);
    assign cnt_full  = (count_ext >= limit);

    assign pos_m1   = pos_reg - CNT_W'(1);
    assign count_m1 = count_reg - CNT_W'(1);

    // The one shared subtractor serves the insertion compare and every span.
    assign sub_diff = sub_a - sub_b;
    assign best_min = (sub_diff[VAL_W-1:0] < best_reg) ? sub_diff[VAL_W-1:0] : best_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_span_next   = res_span_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[ADDR_W-1:0];
        ram_wdata       = val_reg;
        ram_raddr       = '0;
        sub_a           = {ram_rdata[VAL_W-1], ram_rdata};
        sub_b           = {prev_reg[VAL_W-1], prev_reg};

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next        = item.value;
                    res_status_next = ST_OK;
                    res_span_next   = '0;
                    state_next      = S_EMIT;
                    case (item.operation)
                        OP_ADD:
                        begin
                            if (cnt_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = item.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        OP_SHORT:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                res_status_next = ST_FEW;
                            end
                            else
                            begin
                                state_next = S_SH_START;
                            end
                        end
                        OP_LONG:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                res_status_next = ST_FEW;
                            end
                            else
                            begin
                                state_next = S_LG_START;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                ram_raddr  = pos_m1[ADDR_W-1:0];
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                sub_a = {val_reg[VAL_W-1], val_reg};
                sub_b = {ram_rdata[VAL_W-1], ram_rdata};
                ram_we = 1'b1;
                if (sub_diff[VAL_W])
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_m1;
                    if (pos_m1 == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_EMIT;
                end
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_EMIT;
            end
            S_SH_START:
            begin
                ram_raddr  = '0;
                pos_next   = CNT_W'(1);
                state_next = S_SH_PRIME;
            end
            S_SH_PRIME:
            begin
                prev_next  = ram_rdata;
                best_next  = '1;
                ram_raddr  = pos_reg[ADDR_W-1:0];
                pos_next   = pos_reg + CNT_W'(1);
                state_next = S_SH_WALK;
            end
            S_SH_WALK:
            begin
                prev_next = ram_rdata;
                if (pos_reg == count_reg)
                begin
                    res_span_next = best_min;
                    state_next    = S_EMIT;
                end
                else
                begin
                    best_next = best_min;
                    ram_raddr = pos_reg[ADDR_W-1:0];
                    pos_next  = pos_reg + CNT_W'(1);
                end
            end
            S_LG_START:
            begin
                ram_raddr  = '0;
                state_next = S_LG_PRIME;
            end
            S_LG_PRIME:
            begin
                prev_next  = ram_rdata;
                ram_raddr  = count_m1[ADDR_W-1:0];
                state_next = S_LG_CALC;
            end
            S_LG_CALC:
            begin
                res_span_next = sub_diff[VAL_W-1:0];
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = res_status_reg;
                    out_item_next.span   = res_span_reg;
                    out_item_next.count  = COUNT_W'(count_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (capacity_we)
            begin
                cap_reg <= capacity_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        prev_reg       <= prev_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_span_reg   <= res_span_next;
        out_item_reg   <= out_item_next;
    end

    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_ADD && cnt_full) |=> count_reg == $past(count_reg))
        else $error("Rejected add changed the count.");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES) ##1 count_reg >= $past(count_reg))
        else $error("Count decreased or exceeded the store size.");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("Result appeared without passing through emit.");

    a_bad_status_no_span: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status != ST_OK) |-> out_item_reg.span == '0)
        else $error("Span is nonzero on a failing result.");

endmodule
